@@ hw/rtl/tgs_pkg.sv @@
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared constants for the tridiagonal Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package tgs_pkg;
  localparam int unsigned MaxRowsDef   = 64;
  localparam int unsigned ValueBitsDef = 48;
  localparam int unsigned FracBits     = 32;
  localparam int unsigned TolBits      = 47;
  localparam int unsigned IterBits     = 16;
  localparam int unsigned CfgDataBits  = 47;
  localparam int unsigned RowIdxBits   = 6;
  localparam logic [46:0] TolReset     = 47'd1;
  localparam logic [15:0] IterReset    = 16'd1000;
  localparam logic CfgIdxTol  = 1'b0;
  localparam logic CfgIdxIter = 1'b1;
endpackage

@@ hw/rtl/tridiagonal_gauss_seidel_solver.sv @@
// ----------------------------------------------------------------------------
// tridiagonal_gauss_seidel_solver
// Loads tridiagonal rows into memories, runs Gauss-Seidel sweeps, then
// streams the solution one entry at a time in row order.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// start     in   start_i & !busy_o      lower/diagonal/upper/rhs/guess, last_row
// result    out  result_valid_o         solution_value .. last_result
// config    in   cfg_we_i               cfg_index_i, cfg_data_i
//
// Load: one row item per cycle, busy_o stays low until the last_row item.
// Solve: each row is read, takes the multiplies it needs (lower by x[i-1],
//   upper by x[i+1]), is divided by the diagonal and written back; a zero
//   pivot skips the divide. Each sweep ends with a convergence check.
//   Sweeps repeat up to the limit.
// Output: one entry per row in row order, then idle. Reset clears control only;
//   memories hold garbage until rows are written. The receiver cannot stall.
module tridiagonal_gauss_seidel_solver #(
  parameter int unsigned MAX_ROWS   = tgs_pkg::MaxRowsDef,
  parameter int unsigned VALUE_BITS = tgs_pkg::ValueBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [VALUE_BITS-1:0]  lower_entry_i,
  input  logic signed [VALUE_BITS-1:0]  diagonal_entry_i,
  input  logic signed [VALUE_BITS-1:0]  upper_entry_i,
  input  logic signed [VALUE_BITS-1:0]  rhs_value_i,
  input  logic signed [VALUE_BITS-1:0]  guess_value_i,
  input  logic                          last_row_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [tgs_pkg::CfgDataBits-1:0] cfg_data_i,
  output logic                          result_valid_o,
  output logic signed [VALUE_BITS-1:0]  solution_value_o,
  output logic [tgs_pkg::RowIdxBits-1:0] row_index_o,
  output logic                          converged_o,
  output logic [tgs_pkg::IterBits-1:0]  sweeps_used_o,
  output logic                          zero_pivot_o,
  output logic                          last_result_o
);
  import tgs_pkg::*;
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned AB = $clog2(MAX_ROWS);
  localparam int unsigned NB = $clog2(MAX_ROWS + 1);

  // controller states
  localparam logic [3:0] S_LOAD = 4'd0, S_RD = 4'd1, S_RDW = 4'd2,
    S_M1 = 4'd3, S_M1W = 4'd4, S_M2 = 4'd5, S_M2W = 4'd6, S_DV = 4'd7,
    S_DVW = 4'd8, S_WB = 4'd9, S_END = 4'd10, S_ORD = 4'd11, S_OUT = 4'd12;

  // row memory: {lower, diag, upper, rhs}; solution memory separate
  logic [4*VB-1:0] coef_mem [MAX_ROWS];
  logic [VB-1:0]   sol_mem  [MAX_ROWS];

  logic [3:0]    st_q;
  logic [TolBits-1:0]  tol_q;
  logic [IterBits-1:0] lim_q, sweep_q;
  logic [NB-1:0] n_q;
  logic [AB-1:0] row_q;
  logic [VB-1:0] prev_q;     // x[i-1] of this sweep, forwarded
  logic [VB-1:0] cur_q, next_q, sum_q, nv_q;
  logic [VB-1:0] chg_q;
  logic          conv_q, zp_q;
  logic [4*VB-1:0] coef_rd_q;
  logic [VB-1:0] sol_rd_q, sol_rd2_q;
  logic          out_v_q;
  logic [VB-1:0] out_val_q;
  logic [AB-1:0] out_row_q;
  logic          out_last_q;

  logic signed [VB-1:0] c_l, c_d, c_u, c_b;
  assign c_l = coef_rd_q[4*VB-1:3*VB];
  assign c_d = coef_rd_q[3*VB-1:2*VB];
  assign c_u = coef_rd_q[2*VB-1:VB];
  assign c_b = coef_rd_q[VB-1:0];

  logic                 mgo, mdone, dgo, ddone;
  logic signed [VB-1:0] ma, mb, mp, dq;
  logic last_idx, first_idx;
  assign first_idx = (row_q == '0);
  assign last_idx  = ({1'b0, row_q} + 1'b1) == (NB+1)'(n_q);

  tgs_mul #(.VB(VB)) u_mul (.clk_i, .rst_ni, .go_i(mgo), .a_i(ma), .b_i(mb),
    .done_o(mdone), .p_o(mp));
  tgs_div #(.VB(VB)) u_div (.clk_i, .rst_ni, .go_i(dgo), .n_i(sum_q),
    .d_i(c_d), .done_o(ddone), .q_o(dq));

  assign mgo = (st_q == S_M1) || (st_q == S_M2);
  assign ma  = (st_q == S_M1) ? c_l : c_u;
  assign mb  = (st_q == S_M1) ? prev_q : next_q;
  // a zero pivot must not leave the divider running into the next row
  assign dgo = (st_q == S_DV) && (c_d != '0);

  function automatic logic [VB-1:0] ssub(logic [VB-1:0] a, logic [VB-1:0] b);
    logic [VB:0] d;
    d = {a[VB-1], a} - {b[VB-1], b};
    if (d[VB] != d[VB-1]) ssub = d[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    else ssub = d[VB-1:0];
  endfunction

  logic [VB-1:0] diff_a, diff_b, chg_w;
  assign diff_a = $signed(nv_q) >= $signed(cur_q) ? nv_q : cur_q;
  assign diff_b = $signed(nv_q) >= $signed(cur_q) ? cur_q : nv_q;
  assign chg_w  = diff_a - diff_b;

  logic accept, room;
  assign busy_o = (st_q != S_LOAD);
  assign accept = start_i && !busy_o;
  assign room   = n_q < NB'(MAX_ROWS);

  // memory reads, registered
  logic [AB-1:0] rd_a, rd_b;
  always_comb begin
    rd_a = row_q;
    rd_b = last_idx ? row_q : AB'(row_q + 1'b1);
  end
  always_ff @(posedge clk_i) begin
    if (accept && room) begin
      coef_mem[n_q[AB-1:0]] <= {lower_entry_i, diagonal_entry_i, upper_entry_i,
                               rhs_value_i};
    end
    coef_rd_q <= coef_mem[rd_a];
  end
  always_ff @(posedge clk_i) begin
    if (accept && room) sol_mem[n_q[AB-1:0]] <= guess_value_i;
    else if (st_q == S_WB) sol_mem[row_q] <= nv_q;
    sol_rd_q  <= sol_mem[rd_a];
    sol_rd2_q <= sol_mem[rd_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; tol_q <= TolReset; lim_q <= IterReset; n_q <= '0;
      row_q <= '0; sweep_q <= '0; conv_q <= 1'b0; zp_q <= 1'b0; chg_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgIdxTol) tol_q <= cfg_data_i[TolBits-1:0];
        else lim_q <= cfg_data_i[IterBits-1:0];
      end
      unique case (st_q)
        S_LOAD: if (accept) begin
          if (room) n_q <= n_q + 1'b1;
          if (last_row_i) begin
            st_q <= S_RD; row_q <= '0; sweep_q <= '0; chg_q <= '0;
            conv_q <= 1'b0; zp_q <= 1'b0;
          end
        end
        S_RD:  st_q <= S_RDW;
        S_RDW: begin
          cur_q <= sol_rd_q; next_q <= sol_rd2_q; sum_q <= c_b;
          st_q <= first_idx ? (last_idx ? S_DV : S_M2) : S_M1;
        end
        S_M1:  st_q <= S_M1W;
        S_M1W: if (mdone) begin
          sum_q <= ssub(sum_q, mp);
          st_q <= last_idx ? S_DV : S_M2;
        end
        S_M2:  st_q <= S_M2W;
        S_M2W: if (mdone) begin
          sum_q <= ssub(sum_q, mp);
          st_q <= S_DV;
        end
        S_DV: begin
          if (c_d == '0) begin
            zp_q <= 1'b1; nv_q <= cur_q; st_q <= S_WB;
          end else st_q <= S_DVW;
        end
        S_DVW: if (ddone) begin
          nv_q <= dq; st_q <= S_WB;
        end
        S_WB: begin
          if (chg_w > chg_q) chg_q <= chg_w;
          prev_q <= nv_q;
          if (last_idx) st_q <= S_END;
          else begin
            row_q <= row_q + 1'b1; st_q <= S_RD;
          end
        end
        S_END: begin
          sweep_q <= sweep_q + 1'b1; row_q <= '0; chg_q <= '0;
          if (chg_q < {1'b0, tol_q}) begin
            conv_q <= 1'b1; st_q <= S_ORD;
          end else if ((sweep_q + 1'b1) >= ((lim_q == '0) ? IterBits'(1) : lim_q))
            st_q <= S_ORD;
          else st_q <= S_RD;
        end
        S_ORD: st_q <= S_OUT;  // first read in flight
        S_OUT: begin
          out_v_q <= 1'b1; out_val_q <= sol_rd_q; out_row_q <= row_q;
          out_last_q <= last_idx;
          if (last_idx) begin
            st_q <= S_LOAD; n_q <= '0;
          end else begin
            row_q <= row_q + 1'b1; st_q <= S_ORD;
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  assign result_valid_o   = out_v_q;
  assign solution_value_o = out_val_q;
  assign row_index_o      = RowIdxBits'(out_row_q);
  assign converged_o      = conv_q;
  assign sweeps_used_o    = sweep_q;
  assign zero_pivot_o     = zp_q;
  assign last_result_o    = out_last_q;

  // results are valid only while busy or when the previous state was the output state
  a_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o || $past(st_q) == S_OUT) else $error("acc");
  // results only follow the output state
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(st_q) == S_OUT) else $error("res");
  // fill count never exceeds capacity
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NB'(MAX_ROWS)) else $error("fill");
endmodule

@@ hw/rtl/tgs_mul.sv @@
// ----------------------------------------------------------------------------
// tgs_mul
// Saturating fixed-point multiply, built from four 32x32 partial products;
// operands, partial products and the result are registered in turn.
// ----------------------------------------------------------------------------
module tgs_mul #(
  parameter int unsigned VB = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic signed [VB-1:0] a_i,
  input  logic signed [VB-1:0] b_i,
  output logic                 done_o,
  output logic signed [VB-1:0] p_o
);
  import tgs_pkg::*;
  localparam int unsigned HB = 32;
  logic [1:0]    ph_q, ph_d;
  logic          neg_q;
  logic [VB-1:0] ma_q, mb_q;
  logic [63:0]   p00_q, p01_q, p10_q, p11_q;
  logic [VB-1:0] ma_w, mb_w;
  logic [63:0]   a64, b64;
  logic [127:0]  full;
  logic [127:0]  shr;
  logic          over;
  logic [VB-1:0] res;
  logic [VB-1:0] vmax;

  assign ma_w = a_i[VB-1] ? VB'(-a_i) : VB'(a_i);
  assign mb_w = b_i[VB-1] ? VB'(-b_i) : VB'(b_i);
  assign a64  = 64'(ma_q);
  assign b64  = 64'(mb_q);
  assign vmax = {1'b0, {(VB-1){1'b1}}};

  always_comb begin
    full = {p11_q, 64'd0} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
         + {64'd0, p00_q};
    shr  = full >> FracBits;
    over = (shr[127:VB-1] != '0);
    if (!neg_q) res = (over) ? vmax : shr[VB-1:0];
    else if (over && !(shr[127:VB-1] == 1 && shr[VB-2:0] == '0)) res = ~vmax;
    else res = VB'(-shr[VB-1:0]);
  end

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      2'd0: if (go_i) ph_d = 2'd1;
      2'd1: ph_d = 2'd2;
      2'd2: ph_d = 2'd3;
      default: ph_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= 2'd0;
    else ph_q <= ph_d;
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == 2'd0 && go_i) begin
      ma_q  <= ma_w;
      mb_q  <= mb_w;
      neg_q <= a_i[VB-1] ^ b_i[VB-1];
    end
    if (ph_q == 2'd1) begin
      p00_q <= a64[HB-1:0] * b64[HB-1:0];
      p01_q <= a64[HB-1:0] * b64[63:HB];
      p10_q <= a64[63:HB] * b64[HB-1:0];
      p11_q <= a64[63:HB] * b64[63:HB];
    end
    if (ph_q == 2'd2) p_o <= res;
  end
  assign done_o = (ph_q == 2'd3);
endmodule

@@ hw/rtl/tgs_div.sv @@
// ----------------------------------------------------------------------------
// tgs_div
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module tgs_div #(
  parameter int unsigned VB = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic signed [VB-1:0] n_i,
  input  logic signed [VB-1:0] d_i,
  output logic                 done_o,
  output logic signed [VB-1:0] q_o
);
  import tgs_pkg::*;
  localparam int unsigned NB = VB + FracBits;
  localparam int unsigned CB = $clog2(NB + 1);
  logic          busy_q, fin_q;
  logic [CB-1:0] cnt_q;
  logic [NB-1:0] num_q, quo_q;
  logic [VB:0]   rem_q, rtry;
  logic [VB-1:0] den_q;
  logic          neg_q;
  logic [VB-1:0] vmax;
  logic          over;

  assign vmax = {1'b0, {(VB-1){1'b1}}};
  assign rtry = {rem_q[VB-1:0], num_q[NB-1]};
  assign over = (quo_q[NB-1:VB-1] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (go_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CB'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && !busy_q) begin
      num_q <= {(n_i[VB-1] ? VB'(-n_i) : VB'(n_i)), {FracBits{1'b0}}};
      den_q <= d_i[VB-1] ? VB'(-d_i) : VB'(d_i);
      neg_q <= n_i[VB-1] ^ d_i[VB-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (rtry >= {1'b0, den_q}) begin
        rem_q <= rtry - {1'b0, den_q};
        quo_q <= {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= rtry;
        quo_q <= {quo_q[NB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg_q) q_o = over ? vmax : quo_q[VB-1:0];
    else if (over) q_o = ~vmax;
    else q_o = VB'(-quo_q[VB-1:0]);
  end
  assign done_o = fin_q;
endmodule
